// ===== rtl/core/filtered_nearest_key_search_core_defines.svh =====
// assertion macros for the filtered nearest-key search core
// used by the checker; needs clk_i and rst_ni in the scope of each use
`ifndef FILTERED_NEAREST_KEY_SEARCH_CORE_DEFINES_SVH
`define FILTERED_NEAREST_KEY_SEARCH_CORE_DEFINES_SVH

// same-cycle implication
`define FNKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fnks check failed");

// next-cycle implication
`define FNKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fnks check failed");

`endif

// ===== rtl/core/fnks_pkg.sv =====
// shared types and constants for the filtered nearest-key search core
// no dependencies
`default_nettype none

package fnks_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);
  localparam int unsigned KeyW       = 24;
  localparam int unsigned ActW       = 2;
  localparam int unsigned StatW      = 3;

  // action codes, the remaining codes clear the table
  localparam logic [ActW-1:0] ActLoad  = 2'd0;
  localparam logic [ActW-1:0] ActQuery = 2'd1;

  // result status codes
  localparam logic [StatW-1:0] StLoaded  = 3'd0;
  localparam logic [StatW-1:0] StDropped = 3'd1;
  localparam logic [StatW-1:0] StFound   = 3'd2;
  localparam logic [StatW-1:0] StNone    = 3'd3;
  localparam logic [StatW-1:0] StCleared = 3'd4;

  typedef enum logic [1:0] {
    StateIdle,
    StateScan,
    StateDrain,
    StateResp
  } state_e;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [KeyW-1:0] entry_key;
    logic [KeyW-1:0] entry_size;
    logic [KeyW-1:0] preferred_key;
    logic [KeyW-1:0] minimum_size;
  } in_beat_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [KeyW-1:0]  best_key;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic scan_rd;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_query;
    logic count_zero;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/fnks_ctrl.sv =====
// controller state machine for the filtered nearest-key search core
// depends on fnks_pkg
`default_nettype none

module fnks_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fnks_pkg::dp_stat_t stat_i,
  output fnks_pkg::dp_cmd_t  cmd_o
);

  fnks_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fnks_pkg::StateIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fnks_pkg::StateIdle: begin
        if (in_valid_i) begin
          if (stat_i.in_query && !stat_i.count_zero) begin
            state_d = fnks_pkg::StateScan;
          end else begin
            state_d = fnks_pkg::StateResp;
          end
        end
      end
      fnks_pkg::StateScan: begin
        if (stat_i.scan_last) begin
          state_d = fnks_pkg::StateDrain;
        end
      end
      fnks_pkg::StateDrain: begin
        state_d = fnks_pkg::StateResp;
      end
      fnks_pkg::StateResp: begin
        if (stat_i.out_free) begin
          state_d = fnks_pkg::StateIdle;
        end
      end
      default: state_d = fnks_pkg::StateIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      fnks_pkg::StateIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      fnks_pkg::StateScan: begin
        cmd_o.scan_rd = 1'b1;
      end
      fnks_pkg::StateDrain: begin
      end
      fnks_pkg::StateResp: begin
        cmd_o.finish = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/fnks_dpath.sv =====
// datapath: entry memory, fill count, scan compare and result register
// depends on fnks_pkg
`default_nettype none

module fnks_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fnks_pkg::in_beat_t  in_beat_i,
  input  fnks_pkg::dp_cmd_t   cmd_i,
  output fnks_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fnks_pkg::out_beat_t out_beat_o
);

  localparam int unsigned EntryW = 2 * fnks_pkg::KeyW;

  // entry memory, size in the upper half, key in the lower
  logic [EntryW-1:0] mem_q [fnks_pkg::TableDepth];

  fnks_pkg::in_beat_t           item_q;
  logic [fnks_pkg::CountW-1:0]  count_q;
  logic [fnks_pkg::AddrW-1:0]   scan_addr_q;
  logic [EntryW-1:0]            rd_data_q;
  logic                         rd_valid_q;
  logic [fnks_pkg::KeyW-1:0]    best_key_q;
  logic [fnks_pkg::KeyW-1:0]    best_dist_q;
  logic                         have_q;
  logic                         out_valid_q;
  fnks_pkg::out_beat_t          out_beat_q;

  logic                         full;
  logic                         is_load;
  logic                         is_query;
  logic [fnks_pkg::KeyW-1:0]    rd_key;
  logic [fnks_pkg::KeyW-1:0]    rd_size;
  logic [fnks_pkg::KeyW-1:0]    key_dist;
  logic                         qualifies;
  logic                         better;
  fnks_pkg::out_beat_t          result;

  assign full     = (count_q == fnks_pkg::CountW'(fnks_pkg::TableDepth));
  assign is_load  = (item_q.action == fnks_pkg::ActLoad);
  assign is_query = (item_q.action == fnks_pkg::ActQuery);
  assign rd_key   = rd_data_q[fnks_pkg::KeyW-1:0];
  assign rd_size  = rd_data_q[EntryW-1:fnks_pkg::KeyW];

  // status back to the controller
  assign stat_o.in_query   = (in_beat_i.action == fnks_pkg::ActQuery);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.scan_last  = ({1'b0, scan_addr_q} == (count_q - fnks_pkg::CountW'(1)));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // distance and candidate compare on the entry read last cycle
  always_comb begin
    if (rd_key >= item_q.preferred_key) begin
      key_dist = rd_key - item_q.preferred_key;
    end else begin
      key_dist = item_q.preferred_key - rd_key;
    end
    qualifies = (rd_size >= item_q.minimum_size);
    better    = !have_q || (key_dist < best_dist_q) ||
                ((key_dist == best_dist_q) && (rd_key < best_key_q));
  end

  // result beat for the item in hand
  always_comb begin
    result = '0;
    priority if (is_load) begin
      result.status = full ? fnks_pkg::StDropped : fnks_pkg::StLoaded;
    end else if (is_query) begin
      result.status   = have_q ? fnks_pkg::StFound : fnks_pkg::StNone;
      result.best_key = have_q ? best_key_q : '0;
    end else begin
      result.status = fnks_pkg::StCleared;
    end
  end

  // memory write on a load that fits, registered scan read
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && is_load && !full) begin
      mem_q[count_q[fnks_pkg::AddrW-1:0]] <= {item_q.entry_size, item_q.entry_key};
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem_q[scan_addr_q];
    end
  end

  // item and best candidate payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_beat_i;
    end
    if (rd_valid_q && qualifies && better) begin
      best_key_q  <= rd_key;
      best_dist_q <= key_dist;
    end
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_addr_q <= '0;
      rd_valid_q  <= 1'b0;
      have_q      <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan_rd;
      if (cmd_i.latch) begin
        scan_addr_q <= '0;
        have_q      <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_addr_q <= scan_addr_q + fnks_pkg::AddrW'(1);
        end
        if (rd_valid_q && qualifies) begin
          have_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (is_load) begin
          if (!full) begin
            count_q <= count_q + fnks_pkg::CountW'(1);
          end
        end else if (!is_query) begin
          count_q <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_beat_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

// ===== rtl/core/filtered_nearest_key_search_core.sv =====
// Filtered nearest-key search core. Holds up to 1024 (key, size) entries in a
// single-port memory. A load beat appends an entry (or reports it dropped when
// full), a clear beat empties the table, and a query beat returns the stored
// key closest to the preferred key among entries of at least the minimum size,
// the smaller key winning a tie. Loads and clears go straight to the response
// state after acceptance. A query reads one entry per cycle from the memory
// port over the N stored entries, then passes through a drain state before the
// response state (an empty table goes straight to the response state). One
// item is in progress at a time: the next beat is taken once the result has
// entered the output register, which holds it until taken. No memory clearing
// is needed after reset.
// depends on fnks_pkg, fnks_ctrl, fnks_dpath
`default_nettype none

module filtered_nearest_key_search_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fnks_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fnks_pkg::out_beat_t out_beat_o
);

  fnks_pkg::dp_cmd_t  cmd;
  fnks_pkg::dp_stat_t stat;

  // sequencing
  fnks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage and compare
  fnks_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/fnks_checker.sv =====
// port-level checks for the filtered nearest-key search core, bound to the top
// depends on fnks_pkg and the assertion macro header
`default_nettype none
`include "filtered_nearest_key_search_core_defines.svh"

module fnks_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input fnks_pkg::in_beat_t  in_beat_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input fnks_pkg::out_beat_t out_beat_o
);

  logic in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // one item at a time: no beat taken straight after another
  `FNKS_ASSERT_NEXT(a_one_in_flight, in_fire, !in_ready_o)

  // status codes stay in range
  `FNKS_ASSERT_NOW(a_status_range, out_valid_o, out_beat_o.status <= fnks_pkg::StCleared)

  // only a found result carries a key
  `FNKS_ASSERT_NOW(a_key_zero, out_valid_o && (out_beat_o.status != fnks_pkg::StFound),
                   out_beat_o.best_key == '0)

  // stalled result beat holds
  `FNKS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(out_beat_o))

endmodule

bind filtered_nearest_key_search_core fnks_checker u_fnks_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o)
);

`default_nettype wire
